// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked property that must also hold during reset.
`define ASSERT_ALL(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== design/pss_pkg.sv =====
// Package for the per-second sampling statistics block.
// Types, codes and helper functions; used by the top level, the divider and the checker.
package pss_pkg;

  localparam int unsigned DEFAULT_SLOTS = 4096;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned CLOSED_W      = 13;
  localparam int unsigned CFG_IDX_W     = 2;

  // action codes
  localparam logic [1:0] ACT_PACKET  = 2'd0;
  localparam logic [1:0] ACT_SAMPLED = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND   = 2'd1;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] timestamp_sec;
    logic [DATA_W-1:0] samp_limit;
    logic [IDX_W-1:0]  read_index;
  } pss_in_t;

  typedef struct packed {
    logic                read_valid;
    logic [DATA_W-1:0]   read_timestamp;
    logic [DATA_W-1:0]   read_packets;
    logic [DATA_W-1:0]   read_sampled;
    logic [DATA_W-1:0]   read_average_limit;
    logic [DATA_W-1:0]   read_below_count;
    logic [CLOSED_W-1:0] slots_closed;
    logic                overflowed;
    logic                slot_closed_now;
  } pss_out_t;

  // one closed slot as stored in the table
  typedef struct packed {
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] packets;
    logic [DATA_W-1:0] sampled;
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] below;
  } pss_slot_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    return (v == '1) ? v : v + DATA_W'(1);
  endfunction

endpackage

// ===== design/per_second_sampling_stats.sv =====
// Top level of the per-second sampling statistics block.
// Uses pss_pkg, pss_ram (slot table) and pss_div (average divider).
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (pss_in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (pss_out_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Packet, sampled and unknown items go straight to the output register; a read
// waits for the registered table read, a slot-closing packet for the average
// divider (one bit per cycle, cut short for no samples or a saturated average).
// One item is in work at a time; input is taken only when the output register
// is empty or transfers in that cycle, so out_stall_i holds the result and
// stalls input. Reset empties the table logically (no clearing pass).
module per_second_sampling_stats #(
  parameter int unsigned SLOTS = pss_pkg::DEFAULT_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pss_pkg::pss_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pss_pkg::pss_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pss_pkg::DATA_W-1:0]       cfg_data_i
);
  import pss_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned SW = $bits(pss_slot_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [DATA_W-1:0]   warn_q, warn_d;
  logic [DATA_W-1:0]   start_q, start_d;
  logic [DATA_W-1:0]   open_time_q, open_time_d;
  logic [DATA_W-1:0]   open_pkts_q, open_pkts_d;
  logic [DATA_W-1:0]   open_samp_q, open_samp_d;
  logic [DATA_W-1:0]   open_below_q, open_below_d;
  logic [2*DATA_W-1:0] lsum_q, lsum_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic                ovf_q, ovf_d;
  logic [DATA_W-1:0]   sec_q, sec_d;
  logic                out_valid_q, out_valid_d;
  pss_out_t            out_q, out_d;

  logic                out_free;
  logic                in_fire;
  logic                full;
  logic [2*DATA_W:0]   lsum_add;
  logic                rd_hit;
  logic [PW-1:0]       pos_inc;

  logic                ram_we;
  logic                ram_re;
  pss_slot_t           ram_wdata;
  logic [SW-1:0]       ram_rdata;
  pss_slot_t           rd_slot;

  logic                div_start;
  logic                div_done;
  logic [DATA_W-1:0]   div_quo;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign full     = (pos_q == PW'(SLOTS));
  assign pos_inc  = pos_q + PW'(1);
  assign lsum_add = {1'b0, lsum_q} + {{(DATA_W+1){1'b0}}, in_data_i.samp_limit};
  assign rd_hit   = (32'(in_data_i.read_index) < 32'(pos_q))
                 && (32'(in_data_i.read_index) < 32'(SLOTS));
  assign rd_slot  = pss_slot_t'(ram_rdata);

  assign ram_wdata = '{stamp:   open_time_q,
                       packets: open_pkts_q,
                       sampled: open_samp_q,
                       average: div_quo,
                       below:   open_below_q};

  always_comb begin
    state_d      = state_q;
    warn_d       = warn_q;
    start_d      = start_q;
    open_time_d  = open_time_q;
    open_pkts_d  = open_pkts_q;
    open_samp_d  = open_samp_q;
    open_below_d = open_below_q;
    lsum_d       = lsum_q;
    pos_d        = pos_q;
    ovf_d        = ovf_q;
    sec_d        = sec_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    div_start    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d              = '0;
          out_d.slots_closed = CLOSED_W'(pos_q);
          out_valid_d        = 1'b1;
          case (in_data_i.action)
            ACT_PACKET: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                open_pkts_d = sat_inc(open_pkts_q);
                if (in_data_i.timestamp_sec > open_time_q) begin
                  // slot closes: result comes after the average is ready
                  sec_d       = in_data_i.timestamp_sec;
                  div_start   = 1'b1;
                  out_valid_d = 1'b0;
                  state_d     = ST_DIV;
                end
              end
            end
            ACT_SAMPLED: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                open_samp_d = sat_inc(open_samp_q);
                lsum_d      = lsum_add[2*DATA_W] ? '1 : lsum_add[2*DATA_W-1:0];
                if (in_data_i.samp_limit < warn_q) begin
                  open_below_d = sat_inc(open_below_q);
                end
              end
            end
            ACT_READ: begin
              if (rd_hit) begin
                ram_re      = 1'b1;
                out_valid_d = 1'b0;
                state_d     = ST_READ;
              end
            end
            default: begin
            end
          endcase
          out_d.overflowed = ovf_d;
        end
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          ram_we       = 1'b1;
          pos_d        = pos_inc;
          open_time_d  = sec_q;
          open_pkts_d  = '0;
          open_samp_d  = '0;
          open_below_d = '0;
          lsum_d       = '0;
          out_d                 = '0;
          out_d.slots_closed    = CLOSED_W'(pos_inc);
          out_d.overflowed      = ovf_q;
          out_d.slot_closed_now = 1'b1;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_d.read_valid         = 1'b1;
          out_d.read_timestamp     = rd_slot.stamp;
          out_d.read_packets       = rd_slot.packets;
          out_d.read_sampled       = rd_slot.sampled;
          out_d.read_average_limit = rd_slot.average;
          out_d.read_below_count   = rd_slot.below;
          out_d.slots_closed       = CLOSED_W'(pos_q);
          out_d.overflowed         = ovf_q;
          out_d.slot_closed_now    = 1'b0;
          out_valid_d              = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // configuration must only be written while no item is in work; the block does not enforce this
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WARN_THRESHOLD: warn_d = cfg_data_i;
        CFG_START_SECOND: begin
          start_d = cfg_data_i;
          if (pos_q == '0) begin
            open_time_d = cfg_data_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      warn_q       <= '0;
      start_q      <= '0;
      open_time_q  <= '0;
      open_pkts_q  <= '0;
      open_samp_q  <= '0;
      open_below_q <= '0;
      lsum_q       <= '0;
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      warn_q       <= warn_d;
      start_q      <= start_d;
      open_time_q  <= open_time_d;
      open_pkts_q  <= open_pkts_d;
      open_samp_q  <= open_samp_d;
      open_below_q <= open_below_d;
      lsum_q       <= lsum_d;
      pos_q        <= pos_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
    out_q <= out_d;
  end

  pss_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[AW-1:0]),
    .wdata_i (SW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (AW'(in_data_i.read_index)),
    .rdata_o (ram_rdata)
  );

  pss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (lsum_q),
    .divisor_i  (open_samp_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/pss_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module pss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pss_div.sv =====
// Restoring divider for the slot average: 64-bit sum by 32-bit count,
// one quotient bit per cycle, saturating to all ones, zero for a zero count. Uses pss_pkg.
module pss_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [2*pss_pkg::DATA_W-1:0] dividend_i,
  input  logic [pss_pkg::DATA_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [pss_pkg::DATA_W-1:0]  quotient_o
);
  import pss_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] div_q, div_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      div_d = divisor_i;
      cnt_d = '0;
      if (divisor_i == '0) begin
        quo_d  = '0;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (dividend_i[2*DATA_W-1:DATA_W] >= divisor_i) begin
        // quotient needs more than 32 bits
        quo_d  = '1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d  = dividend_i[2*DATA_W-1:DATA_W];
        quo_d  = dividend_i[DATA_W-1:0];
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/pss_checker.sv =====
// Port-level checker for per_second_sampling_stats, bound to the top level.
// Uses pss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pss_pkg::pss_out_t out_data_o
);
  import pss_pkg::*;

  // a stalled result stays put
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // every result without a read hit carries all-zero slot fields
  `ASSERT_RST(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_data_o.read_valid |-> out_data_o.read_timestamp == '0 && out_data_o.read_packets == '0 && out_data_o.read_sampled == '0 && out_data_o.read_average_limit == '0 && out_data_o.read_below_count == '0)

  // warnings are only counted on sampled packets
  `ASSERT_RST(a_below_le_sampled, clk_i, rst_ni, out_valid_o && out_data_o.read_valid |-> out_data_o.read_below_count <= out_data_o.read_sampled)

  // a closing item is never a read and never happens once the table is full
  `ASSERT_RST(a_close_clean, clk_i, rst_ni, out_valid_o && out_data_o.slot_closed_now |-> !out_data_o.read_valid && !out_data_o.overflowed)

endmodule

bind per_second_sampling_stats pss_checker u_pss_checker (.*);
